[rtl/core/dbpf_pkg.sv]
package dbpf_pkg;

    localparam int EVENT_BITS     = 3;
    localparam int BANK0_PTR_BITS = 4;
    localparam int BANK1_PTR_BITS = 4;
    localparam int PAYLOAD_BITS   = 64;

    localparam int NUM_EVENTS      = 1 << EVENT_BITS;
    localparam int BANK0_ADDR_BITS = EVENT_BITS + BANK0_PTR_BITS;
    localparam int BANK1_ADDR_BITS = EVENT_BITS + BANK1_PTR_BITS;
    localparam int BANK0_DEPTH     = 1 << BANK0_ADDR_BITS;
    localparam int BANK1_DEPTH     = 1 << BANK1_ADDR_BITS;

    typedef logic [EVENT_BITS-1:0]      event_t;
    typedef logic [PAYLOAD_BITS-1:0]    payload_t;
    typedef logic [BANK0_PTR_BITS-1:0]  ptr0_t;
    typedef logic [BANK1_PTR_BITS-1:0]  ptr1_t;
    typedef logic [BANK0_ADDR_BITS-1:0] addr0_t;
    typedef logic [BANK1_ADDR_BITS-1:0] addr1_t;

    typedef struct packed {
        logic     put0_valid;
        event_t   put0_event;
        payload_t put0_payload;
        logic     put1_valid;
        event_t   put1_event;
        payload_t put1_payload;
        logic     take_enable;
        event_t   take_event;
    } item_t;

    typedef struct packed {
        logic   rd_en0;
        addr0_t rd_addr0;
        logic   rd_en1;
        addr1_t rd_addr1;
        logic   wr_en0;
        addr0_t wr_addr0;
        logic   wr_en1;
        addr1_t wr_addr1;
        logic   hit;
        logic   bank;
        logic   full0;
        logic   full1;
    } ctrl_t;

endpackage

[rtl/core/dbpf_ram.sv]
module dbpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dbpf_ptrs.sv]
module dbpf_ptrs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  dbpf_pkg::item_t item,
    output dbpf_pkg::ctrl_t ctrl
);

    dbpf_pkg::ptr0_t rd0_reg [dbpf_pkg::NUM_EVENTS];
    dbpf_pkg::ptr0_t wr0_reg [dbpf_pkg::NUM_EVENTS];
    dbpf_pkg::ptr1_t rd1_reg [dbpf_pkg::NUM_EVENTS];
    dbpf_pkg::ptr1_t wr1_reg [dbpf_pkg::NUM_EVENTS];

    dbpf_pkg::ptr0_t take_rd0;
    dbpf_pkg::ptr0_t take_wr0;
    dbpf_pkg::ptr1_t take_rd1;
    dbpf_pkg::ptr1_t take_wr1;
    dbpf_pkg::ptr0_t put_wr0;
    dbpf_pkg::ptr0_t put_nx0;
    dbpf_pkg::ptr1_t put_wr1;
    dbpf_pkg::ptr1_t put_nx1;
    logic            hit0;
    logic            hit1;
    logic            full0;
    logic            full1;
    logic            wr_en0;
    logic            wr_en1;

    always_comb
    begin
        take_rd0 = rd0_reg[item.take_event];
        take_wr0 = wr0_reg[item.take_event];
        take_rd1 = rd1_reg[item.take_event];
        take_wr1 = wr1_reg[item.take_event];
        put_wr0  = wr0_reg[item.put0_event];
        put_wr1  = wr1_reg[item.put1_event];
        put_nx0  = dbpf_pkg::ptr0_t'(put_wr0 + 1'b1);
        put_nx1  = dbpf_pkg::ptr1_t'(put_wr1 + 1'b1);
        full0    = (put_nx0 == rd0_reg[item.put0_event]);
        full1    = (put_nx1 == rd1_reg[item.put1_event]);
        hit0     = item_valid && item.take_enable && (take_rd0 != take_wr0);
        hit1     = item_valid && item.take_enable && !hit0 && (take_rd1 != take_wr1);
        wr_en0   = item_valid && item.put0_valid && !full0;
        wr_en1   = item_valid && item.put1_valid && !full1;

        ctrl.rd_en0   = hit0;
        ctrl.rd_addr0 = {item.take_event, take_rd0};
        ctrl.rd_en1   = hit1;
        ctrl.rd_addr1 = {item.take_event, take_rd1};
        ctrl.wr_en0   = wr_en0;
        ctrl.wr_addr0 = {item.put0_event, put_wr0};
        ctrl.wr_en1   = wr_en1;
        ctrl.wr_addr1 = {item.put1_event, put_wr1};
        ctrl.hit      = hit0 || hit1;
        ctrl.bank     = hit1;
        ctrl.full0    = full0;
        ctrl.full1    = full1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dbpf_pkg::NUM_EVENTS; i++)
            begin
                rd0_reg[i] <= '0;
                wr0_reg[i] <= '0;
                rd1_reg[i] <= '0;
                wr1_reg[i] <= '0;
            end
        end
        else
        begin
            if (hit0)
            begin
                rd0_reg[item.take_event] <= dbpf_pkg::ptr0_t'(take_rd0 + 1'b1);
            end
            if (hit1)
            begin
                rd1_reg[item.take_event] <= dbpf_pkg::ptr1_t'(take_rd1 + 1'b1);
            end
            if (wr_en0)
            begin
                wr0_reg[item.put0_event] <= put_nx0;
            end
            if (wr_en1)
            begin
                wr1_reg[item.put1_event] <= put_nx1;
            end
        end
    end

endmodule

[rtl/core/dual_bank_per_event_fifo_unit.sv]
// A word accepted with start passes the input register, then the result registers.
// Throughput: one word per cycle; busy stays low, since the pointer tables update in
// the cycle after the input register and the bank memories read with one register.
// Reset clears all read and write pointers at once, so every queue starts empty;
// the bank memories are not cleared. Results are strobed by done and cannot stall.
module dual_bank_per_event_fifo_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   put0_valid,
    input  dbpf_pkg::event_t       put0_event,
    input  dbpf_pkg::payload_t     put0_payload,
    input  logic                   put1_valid,
    input  dbpf_pkg::event_t       put1_event,
    input  dbpf_pkg::payload_t     put1_payload,
    input  logic                   take_enable,
    input  dbpf_pkg::event_t       take_event,
    output logic                   done,
    output logic                   got_valid,
    output logic                   got_bank,
    output dbpf_pkg::payload_t     got_payload,
    output logic                   bank0_full,
    output logic                   bank1_full
);

    logic               item_valid_reg;
    dbpf_pkg::item_t    item_reg;
    dbpf_pkg::item_t    item_next;
    dbpf_pkg::ctrl_t    ctrl;
    dbpf_pkg::payload_t q0;
    dbpf_pkg::payload_t q1;
    logic               done_reg;
    logic               got_valid_reg;
    logic               got_bank_reg;
    logic               full0_reg;
    logic               full1_reg;

    assign busy = 1'b0;

    always_comb
    begin
        item_next.put0_valid   = put0_valid;
        item_next.put0_event   = put0_event;
        item_next.put0_payload = put0_payload;
        item_next.put1_valid   = put1_valid;
        item_next.put1_event   = put1_event;
        item_next.put1_payload = put1_payload;
        item_next.take_enable  = take_enable;
        item_next.take_event   = take_event;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item_next;
        end
    end

    dbpf_ptrs u_ptrs (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .ctrl       (ctrl)
    );

    dbpf_ram #(
        .WIDTH (dbpf_pkg::PAYLOAD_BITS),
        .DEPTH (dbpf_pkg::BANK0_DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (ctrl.wr_en0),
        .waddr (ctrl.wr_addr0),
        .wdata (item_reg.put0_payload),
        .re    (ctrl.rd_en0),
        .raddr (ctrl.rd_addr0),
        .rdata (q0)
    );

    dbpf_ram #(
        .WIDTH (dbpf_pkg::PAYLOAD_BITS),
        .DEPTH (dbpf_pkg::BANK1_DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (ctrl.wr_en1),
        .waddr (ctrl.wr_addr1),
        .wdata (item_reg.put1_payload),
        .re    (ctrl.rd_en1),
        .raddr (ctrl.rd_addr1),
        .rdata (q1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            got_valid_reg <= 1'b0;
            got_bank_reg  <= 1'b0;
            full0_reg     <= 1'b0;
            full1_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid_reg;
            if (item_valid_reg)
            begin
                got_valid_reg <= ctrl.hit;
                got_bank_reg  <= ctrl.bank;
                full0_reg     <= ctrl.full0;
                full1_reg     <= ctrl.full1;
            end
        end
    end

    assign done        = done_reg;
    assign got_valid   = got_valid_reg;
    assign got_bank    = got_bank_reg;
    assign bank0_full  = full0_reg;
    assign bank1_full  = full1_reg;
    assign got_payload = !got_valid_reg ? '0 : (got_bank_reg ? q1 : q0);

endmodule

[rtl/core/dbpf_checker.sv]
module dbpf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               take_enable,
    input logic               done,
    input logic               got_valid,
    input logic               got_bank,
    input dbpf_pkg::payload_t got_payload
);

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("A word accepted two cycles ago gave no result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("A result appeared without a word accepted two cycles before.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !got_valid) |-> (!got_bank && (got_payload == '0)))
        else $error("An empty read returned a nonzero bank or payload.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(!take_enable, 2)) |-> !got_valid)
        else $error("A read was reported for a word that requested none.");

endmodule

bind dual_bank_per_event_fifo_unit dbpf_checker u_dbpf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .take_enable (take_enable),
    .done        (done),
    .got_valid   (got_valid),
    .got_bank    (got_bank),
    .got_payload (got_payload)
);
